/* rtl/xms_pkg.sv */
// Shared types, constants and begin-pattern tables for the XML markup segment classifier.
// No dependencies.
package xms_pkg;

  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned OUT_OFF_W   = 32;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_UC_C  = 8'h43;
  localparam logic [7:0] CH_UC_D  = 8'h44;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_T  = 8'h54;

  typedef enum logic [2:0] {
    KIND_COMMENT = 3'd0,
    KIND_PI      = 3'd1,
    KIND_CDATA   = 3'd2,
    KIND_START   = 3'd3,
    KIND_END     = 3'd4,
    KIND_DONE    = 3'd5,
    KIND_ERROR   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_PLAIN  = 3'd2,
    PH_BODY   = 3'd3,
    PH_TAIL   = 3'd4
  } phase_e;

  typedef struct packed {
    kind_e                  kind;
    logic [OUT_OFF_W-1:0]   start_off;
    logic [OUT_OFF_W-1:0]   end_off;
    logic                   last;
  } result_t;

  // length of each begin pattern: comment, pi, cdata
  function automatic logic [3:0] begin_len(input logic [1:0] idx);
    logic [3:0] len;
    len = 4'd0;
    case (idx)
      2'd0:    len = 4'd4;
      2'd1:    len = 4'd2;
      2'd2:    len = 4'd9;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // byte k of begin pattern idx (byte 0 is the '<')
  function automatic logic [7:0] begin_byte(input logic [1:0] idx, input logic [3:0] k);
    logic [7:0] ch;
    ch = CH_NUL;
    case (idx)
      2'd0: begin
        case (k)
          4'd0:    ch = CH_LT;
          4'd1:    ch = CH_BANG;
          4'd2:    ch = CH_DASH;
          4'd3:    ch = CH_DASH;
          default: ch = CH_NUL;
        endcase
      end
      2'd1: begin
        case (k)
          4'd0:    ch = CH_LT;
          4'd1:    ch = CH_QUEST;
          default: ch = CH_NUL;
        endcase
      end
      2'd2: begin
        case (k)
          4'd0:    ch = CH_LT;
          4'd1:    ch = CH_BANG;
          4'd2:    ch = CH_LBRK;
          4'd3:    ch = CH_UC_C;
          4'd4:    ch = CH_UC_D;
          4'd5:    ch = CH_UC_A;
          4'd6:    ch = CH_UC_T;
          4'd7:    ch = CH_UC_A;
          4'd8:    ch = CH_LBRK;
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/xms_scanner.sv */
// Scan state and per-byte step logic: segment tracking, begin/end pattern matching.
// Depends on xms_pkg.
module xms_scanner (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                data_byte_i,
  input  logic                      end_of_file_i,
  output xms_pkg::result_t [1:0]    res_o,
  output logic [1:0]                res_n_o
);
  import xms_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [3:0]             pcount_q, pcount_d;
  logic [2:0]             cand_q, cand_d;
  kind_e                  pend_q, pend_d;
  logic [7:0]             rb0_q, rb0_d;
  logic [7:0]             rb1_q, rb1_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] seg_q, seg_d;

  logic                   is_eof;
  logic [3:0]             k;
  logic [2:0]             match, at_end, hit, keep;
  logic                   close_ok;
  logic [OUT_OFF_W-1:0]   pos_out, seg_out;

  assign is_eof  = end_of_file_i || (data_byte_i == CH_NUL);
  assign k       = pcount_q + 4'd1;
  assign pos_out = OUT_OFF_W'(pos_q);
  assign seg_out = OUT_OFF_W'(seg_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      match[i]  = cand_q[i] && (k < begin_len(2'(i))) && (begin_byte(2'(i), k) == data_byte_i);
      at_end[i] = ((k + 4'd1) == begin_len(2'(i)));
    end
    hit  = match & at_end;
    keep = match & ~at_end;
  end

  always_comb begin
    close_ok = 1'b0;
    case (pend_q)
      KIND_COMMENT: close_ok = (rb0_q == CH_DASH) && (rb1_q == CH_DASH);
      KIND_PI:      close_ok = (rb0_q == CH_QUEST);
      KIND_CDATA:   close_ok = (rb0_q == CH_RBRK) && (rb1_q == CH_RBRK);
      default:      close_ok = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_d  = phase_q;
    pcount_d = pcount_q;
    cand_d   = cand_q;
    pend_d   = pend_q;
    rb0_d    = rb0_q;
    rb1_d    = rb1_q;
    pos_d    = pos_q;
    seg_d    = seg_q;

    if (is_eof) begin
      phase_d  = PH_IDLE;
      pcount_d = 4'd0;
      cand_d   = 3'b111;
      pend_d   = KIND_COMMENT;
      rb0_d    = CH_NUL;
      rb1_d    = CH_NUL;
      pos_d    = '0;
      seg_d    = '0;
    end else begin
      unique case (phase_q)
        PH_PREFIX: begin
          if (k == 4'd1) begin
            pend_d = (data_byte_i == CH_SLASH) ? KIND_END : KIND_START;
          end
          if (hit != 3'b000) begin
            pend_d  = hit[0] ? KIND_COMMENT : (hit[1] ? KIND_PI : KIND_CDATA);
            phase_d = PH_BODY;
          end else if (keep != 3'b000) begin
            cand_d   = keep;
            pcount_d = k;
          end else if (data_byte_i == CH_LT) begin
            seg_d    = pos_q;
            phase_d  = PH_PREFIX;
            pcount_d = 4'd0;
            cand_d   = 3'b111;
          end else begin
            phase_d = PH_PLAIN;
          end
        end
        PH_PLAIN, PH_TAIL: begin
          if (data_byte_i == CH_LT) begin
            seg_d    = pos_q;
            phase_d  = PH_PREFIX;
            pcount_d = 4'd0;
            cand_d   = 3'b111;
          end
        end
        PH_BODY: begin
          if (data_byte_i == CH_GT && close_ok) begin
            phase_d = PH_TAIL;
          end
        end
        PH_IDLE: begin
          if (data_byte_i == CH_LT) begin
            seg_d    = pos_q;
            phase_d  = PH_PREFIX;
            pcount_d = 4'd0;
            cand_d   = 3'b111;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
      rb1_d = rb0_q;
      rb0_d = data_byte_i;
      if (pos_q != {OFFSET_BITS{1'b1}}) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // results
  always_comb begin
    res_o   = '0;
    res_n_o = 2'd0;
    if (is_eof) begin
      unique case (phase_q)
        PH_PREFIX, PH_PLAIN, PH_TAIL: begin
          res_o[0].kind      = (phase_q == PH_PREFIX && pcount_q == 4'd0) ? KIND_START : pend_q;
          res_o[0].start_off = seg_out;
          res_o[0].end_off   = pos_out;
          res_o[0].last      = 1'b0;
          res_o[1].kind      = KIND_DONE;
          res_o[1].start_off = pos_out;
          res_o[1].end_off   = pos_out;
          res_o[1].last      = 1'b1;
          res_n_o            = 2'd2;
        end
        PH_BODY: begin
          res_o[0].kind      = KIND_ERROR;
          res_o[0].start_off = seg_out;
          res_o[0].end_off   = pos_out;
          res_o[0].last      = 1'b1;
          res_n_o            = 2'd1;
        end
        default: begin
          res_o[0].kind      = KIND_DONE;
          res_o[0].start_off = pos_out;
          res_o[0].end_off   = pos_out;
          res_o[0].last      = 1'b1;
          res_n_o            = 2'd1;
        end
      endcase
    end else if (data_byte_i == CH_LT &&
                 (phase_q == PH_PLAIN || phase_q == PH_TAIL ||
                  (phase_q == PH_PREFIX && hit == 3'b000 && keep == 3'b000))) begin
      // a new '<' closes the open segment
      res_o[0].kind      = (phase_q == PH_PREFIX && pcount_q == 4'd0) ? KIND_START : pend_q;
      res_o[0].start_off = seg_out;
      res_o[0].end_off   = pos_out;
      res_o[0].last      = 1'b1;
      res_n_o            = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pcount_q <= 4'd0;
      cand_q   <= 3'b111;
      pend_q   <= KIND_COMMENT;
      rb0_q    <= CH_NUL;
      rb1_q    <= CH_NUL;
      pos_q    <= '0;
      seg_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pcount_q <= pcount_d;
      cand_q   <= cand_d;
      pend_q   <= pend_d;
      rb0_q    <= rb0_d;
      rb1_q    <= rb1_d;
      pos_q    <= pos_d;
      seg_q    <= seg_d;
    end
  end

endmodule

/* rtl/xms_out_fifo.sv */
// Result queue: takes up to two result words per cycle, hands out one per cycle while the output is not stalled.
// Depends on xms_pkg.
module xms_out_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [1:0]              push_n_i,
  input  xms_pkg::result_t [1:0]  push_data_i,
  output logic                    room_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output xms_pkg::result_t        out_data_o
);
  import xms_pkg::*;

  result_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0]   count_q, count_d;
  logic                 pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // two free slots needed, as an end-of-file byte can make two words
  assign room_o      = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));

  assign wr_ptr_d = wr_ptr_q + FIFO_AW'(push_n_i);
  assign rd_ptr_d = rd_ptr_q + FIFO_AW'(pop);
  assign count_d  = count_q + FIFO_CW'(push_n_i) - FIFO_CW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data_i[0];
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_q + FIFO_AW'(1)] <= push_data_i[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/xml_markup_segment_classifier.sv */
// XML markup segment classifier. One text byte per word in; one segment result per word
// out. Throughput is one byte per cycle while the input is not stalled: an accepted byte is
// held in the input register and stepped once the queue has room, its results entering a
// four-word result queue that drives the output port. An end-of-file byte can give two words
// (pending segment, then done), and the output port takes one word a cycle while it is not
// stalled, so the input stalls while fewer than two queue slots are free. Results are written
// into the registered result queue when the byte is stepped and reach the output port from it.
// Depends on xms_pkg, xms_scanner, xms_out_fifo.
module xml_markup_segment_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  segment_kind_o,
  output logic [31:0] start_offset_o,
  output logic [31:0] end_offset_o,
  output logic        last_of_run_o
);
  import xms_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic [7:0]       data_q;
  logic             eof_q;
  logic             in_accept;
  logic             step_go;
  logic             room;
  result_t [1:0]    res;
  logic [1:0]       res_n;
  logic [1:0]       push_n;
  result_t          head;

  assign step_go    = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !step_go);
  assign push_n     = step_go ? res_n : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q <= data_byte_i;
      eof_q  <= end_of_file_i;
    end
  end

  xms_scanner u_scanner (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step_go),
    .data_byte_i   (data_q),
    .end_of_file_i (eof_q),
    .res_o         (res),
    .res_n_o       (res_n)
  );

  xms_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (head)
  );

  assign segment_kind_o = head.kind;
  assign start_offset_o = head.start_off;
  assign end_offset_o   = head.end_off;
  assign last_of_run_o  = head.last;

  // end of file always yields at least one word
  a_eof_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go && eof_q |-> res_n != 2'd0)
    else $error("end of file stepped without a result");

  // done and error words close a run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (segment_kind_o == KIND_DONE || segment_kind_o == KIND_ERROR)
    |-> last_of_run_o)
    else $error("done or error word not marked last");

  // a word that is not last has its partner queued behind it
  a_partner_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("first word of a pair left without its partner");

  // a byte is stepped only with room for two words
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n != 2'd0 |-> room)
    else $error("result queue pushed without room");

endmodule
